[design/bspf_pkg.sv]
// Shared types and constants for the byte serial port with receive and transmit rings.
package bspf_pkg;

   localparam logic [2:0] KIND_READ_DATA   = 3'd0;
   localparam logic [2:0] KIND_READ_STATUS = 3'd1;
   localparam logic [2:0] KIND_WRITE_DATA  = 3'd2;
   localparam logic [2:0] KIND_WRITE_CTRL  = 3'd3;
   localparam logic [2:0] KIND_LINK_BYTE   = 3'd4;
   localparam logic [2:0] KIND_LINK_SEND   = 3'd5;
   localparam logic [2:0] KIND_LINK_STATE  = 3'd6;

   localparam int STATUS_CONN_BIT  = 0;
   localparam int STATUS_RXRDY_BIT = 1;
   localparam int STATUS_TXRDY_BIT = 2;

   localparam logic [7:0] EMPTY_BYTE = 8'hFF;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] bus_data;
      logic [7:0] link_byte;
      logic       link_up;
   } request_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] send_byte;
      logic       send_valid;
      logic       link_taken;
   } response_type;

endpackage

[design/byte_serial_port_fifos.sv]
// Byte serial port top level: receive and transmit rings between a bus and a link partner.
// Each request returns exactly one response. A request is taken every cycle when the
// response side keeps up. The edge that takes a request updates the ring and registers
// the ring read; the response register is loaded when that stage moves on, which waits
// while the response side stalls. Both rings are RING_DEPTH bytes and need no clearing
// after reset.
module byte_serial_port_fifos
   import bspf_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  request_type  req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output response_type rsp_data
);

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
   localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(RING_DEPTH);

   logic [7:0] rx_mem [RING_DEPTH];
   logic [7:0] tx_mem [RING_DEPTH];

   logic [IDX_W-1:0] rx_head_ff, rx_head_in, tx_head_ff, tx_head_in;
   logic [CNT_W-1:0] rx_count_ff, rx_count_in, tx_count_ff, tx_count_in;
   logic             connected_ff, connected_in;

   logic [7:0] rx_rd_ff, tx_rd_ff;
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_rx_pop_ff, s1_tx_pop_ff, s1_taken_ff;
   logic       rsp_valid_ff;
   response_type rsp_ff, rsp_in;

   logic accept, s1_move;
   logic rx_empty, rx_full, tx_empty, tx_full;
   logic rx_pop, rx_push, tx_pop, tx_push;
   logic [SUM_W-1:0] rx_sum, tx_sum;
   logic [IDX_W-1:0] rx_wr_idx, tx_wr_idx;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign rx_empty = (rx_count_ff == '0);
   assign rx_full  = (rx_count_ff == CNT_FULL);
   assign tx_empty = (tx_count_ff == '0);
   assign tx_full  = (tx_count_ff == CNT_FULL);

   assign rx_pop  = accept && (req_data.kind == KIND_READ_DATA) && !rx_empty;
   assign rx_push = accept && (req_data.kind == KIND_LINK_BYTE) && connected_ff && !rx_full;
   assign tx_push = accept && (req_data.kind == KIND_WRITE_DATA) && !tx_full;
   assign tx_pop  = accept && (req_data.kind == KIND_LINK_SEND) && connected_ff && !tx_empty;

   // write index = (head + count) mod depth, sum stays below twice the depth
   assign rx_sum = SUM_W'(rx_head_ff) + SUM_W'(rx_count_ff);
   assign tx_sum = SUM_W'(tx_head_ff) + SUM_W'(tx_count_ff);
   assign rx_wr_idx = (rx_sum >= SUM_DEPTH) ? IDX_W'(rx_sum - SUM_DEPTH) : IDX_W'(rx_sum);
   assign tx_wr_idx = (tx_sum >= SUM_DEPTH) ? IDX_W'(tx_sum - SUM_DEPTH) : IDX_W'(tx_sum);

   always_comb begin
      rx_head_in   = rx_head_ff;
      rx_count_in  = rx_count_ff;
      tx_head_in   = tx_head_ff;
      tx_count_in  = tx_count_ff;
      connected_in = connected_ff;
      if (rx_pop) begin
         rx_head_in  = (rx_head_ff == IDX_LAST) ? '0 : rx_head_ff + 1'b1;
         rx_count_in = rx_count_ff - 1'b1;
      end
      if (rx_push) begin
         rx_count_in = rx_count_ff + 1'b1;
      end
      if (tx_pop) begin
         tx_head_in  = (tx_head_ff == IDX_LAST) ? '0 : tx_head_ff + 1'b1;
         tx_count_in = tx_count_ff - 1'b1;
      end
      if (tx_push) begin
         tx_count_in = tx_count_ff + 1'b1;
      end
      if (accept && (req_data.kind == KIND_LINK_STATE)) begin
         connected_in = req_data.link_up;
      end
   end

   always_comb begin
      s1_byte_in = '0;
      case (req_data.kind)
         KIND_READ_DATA: begin
            s1_byte_in = EMPTY_BYTE;
         end
         KIND_READ_STATUS: begin
            s1_byte_in[STATUS_CONN_BIT]  = connected_ff;
            s1_byte_in[STATUS_RXRDY_BIT] = !rx_empty;
            s1_byte_in[STATUS_TXRDY_BIT] = !tx_full;
         end
         default: begin
            s1_byte_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_in.read_data  = s1_rx_pop_ff ? rx_rd_ff : s1_byte_ff;
      rsp_in.send_byte  = s1_tx_pop_ff ? tx_rd_ff : '0;
      rsp_in.send_valid = s1_tx_pop_ff;
      rsp_in.link_taken = s1_taken_ff;
   end

   always_ff @(posedge clock) begin
      if (rx_push) begin
         rx_mem[rx_wr_idx] <= req_data.link_byte;
      end
      if (tx_push) begin
         tx_mem[tx_wr_idx] <= req_data.bus_data;
      end
      if (accept) begin
         rx_rd_ff <= rx_mem[rx_head_ff];
         tx_rd_ff <= tx_mem[tx_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff   <= '0;
         rx_count_ff  <= '0;
         tx_head_ff   <= '0;
         tx_count_ff  <= '0;
         connected_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_head_ff   <= rx_head_in;
         rx_count_ff  <= rx_count_in;
         tx_head_ff   <= tx_head_in;
         tx_count_ff  <= tx_count_in;
         connected_ff <= connected_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff   <= s1_byte_in;
         s1_rx_pop_ff <= rx_pop;
         s1_tx_pop_ff <= tx_pop;
         s1_taken_ff  <= rx_push;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
